// ----- rtl/first_fit_capacity_allocator_core_macros.svh -----
// ----------------------------------------------------------------------------
// First-fit capacity allocator: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_CAPACITY_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_CAPACITY_ALLOCATOR_CORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define FFCA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define FFCA_ASSERT_NEXT(lbl, cond, nxt, msg) \
	`FFCA_ASSERT(lbl, (cond) |=> (nxt), msg)

`endif

// ----- rtl/ffca_pkg.sv -----
// ----------------------------------------------------------------------------
// First-fit capacity allocator: package
// Field widths, defaults and the item record that travels along the chain.
// ----------------------------------------------------------------------------
package ffca_pkg;

	localparam int SLOT_COUNT_DEF    = 1024;
	localparam int CAPACITY_BITS_DEF = 32;

	localparam int SLOT_W     = 10;
	localparam int AMOUNT_W   = 32;
	localparam int GRANT_W    = 11;
	localparam int LIMIT_W    = 11;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 16;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_ALLOC = 1'b1
	} ffca_req_t;

	typedef enum logic {
		REG_ENTRIES_IN_USE = 1'b0
	} ffca_reg_t;

	typedef struct packed {
		logic                valid;
		ffca_req_t           kind;
		logic                done;
		logic [SLOT_W-1:0]   slot;
		logic [AMOUNT_W-1:0] amount;
		logic [GRANT_W-1:0]  grant;
	} ffca_item_t;

endpackage

// ----- rtl/ffca_cell.sv -----
// ----------------------------------------------------------------------------
// First-fit capacity allocator: slot cell
// Holds one slot's remaining capacity and registers the passing item.
// ----------------------------------------------------------------------------
module ffca_cell #(
	parameter int CELL_INDEX    = 0,
	parameter int CAPACITY_BITS = ffca_pkg::CAPACITY_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic [ffca_pkg::LIMIT_W-1:0] limit,
	input  ffca_pkg::ffca_item_t         item_in,
	output ffca_pkg::ffca_item_t         item_out
);
	import ffca_pkg::*;

	localparam int CMP_W = (CAPACITY_BITS > AMOUNT_W) ? CAPACITY_BITS : AMOUNT_W;
	localparam bit LOADABLE = CELL_INDEX < (1 << SLOT_W);
	localparam bit COUNTABLE = CELL_INDEX < (1 << LIMIT_W);
	localparam logic [SLOT_W-1:0] SLOT_ID = SLOT_W'(CELL_INDEX);
	localparam logic [LIMIT_W-1:0] LIMIT_ID = LIMIT_W'(CELL_INDEX);
	localparam logic [GRANT_W-1:0] GRANT_ID = GRANT_W'(CELL_INDEX + 1);

	logic [CAPACITY_BITS-1:0] cap_q;
	logic                     valid_s1;
	ffca_item_t               item_s1;
	ffca_item_t               item_next;
	logic [CMP_W-1:0]         cap_ext;
	logic [CMP_W-1:0]         amt_ext;
	logic [CMP_W-1:0]         diff;
	logic                     in_use;
	logic                     hit;
	logic                     load;

	assign cap_ext = CMP_W'(cap_q);
	assign amt_ext = CMP_W'(item_in.amount);
	assign diff    = cap_ext - amt_ext;
	assign in_use  = COUNTABLE && (LIMIT_ID < limit);
	assign hit     = item_in.valid && (item_in.kind == REQ_ALLOC) && !item_in.done &&
	                 in_use && (cap_ext >= amt_ext);
	assign load    = item_in.valid && (item_in.kind == REQ_LOAD) && LOADABLE &&
	                 (item_in.slot == SLOT_ID);

	always_ff @(posedge clk) begin
		if (advance) begin
			if (load) begin
				cap_q <= CAPACITY_BITS'(amt_ext);
			end else if (hit) begin
				cap_q <= CAPACITY_BITS'(diff);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_comb begin
		item_next       = item_in;
		item_next.done  = item_in.done | hit;
		item_next.grant = hit ? GRANT_ID : item_in.grant;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1 <= item_next;
		end
	end

	always_comb begin
		item_out       = item_s1;
		item_out.valid = valid_s1;
	end

endmodule

// ----- rtl/first_fit_capacity_allocator_core.sv -----
// ----------------------------------------------------------------------------
// First-fit capacity allocator: top level
// A row of slot cells; every item walks the row from slot 0 upwards.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         tuser: req_type; tdata: slot_index, amount
//  m_axis    out        tdata: granted_slot (one item per request, none per load)
//  apb       in/out     register 0: entries_in_use
//
// Each item walks the row one cell per cycle while the row advances, and a
// new item may enter in every such cycle, since a later item reaches each cell
// only after an earlier one has updated it. The whole row advances together;
// a request result held at the output stops the row and lowers s_tready.
// Reset clears the item valid bits and sets the register to 1024; capacities
// are undefined until loaded.
// ----------------------------------------------------------------------------
module first_fit_capacity_allocator_core #(
	parameter int SLOT_COUNT    = ffca_pkg::SLOT_COUNT_DEF,
	parameter int CAPACITY_BITS = ffca_pkg::CAPACITY_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// slot_index [9:0], amount [41:10], zero fill [47:42]
	input  logic [ffca_pkg::IN_DATA_W-1:0]  s_tdata,
	// req_type [0]
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// granted_slot [10:0], zero fill [15:11]
	output logic [ffca_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ffca_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ffca_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ffca_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import ffca_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic               advance;
	ffca_item_t         chain [SLOT_COUNT+1];
	ffca_item_t         last;

	assign pready = 1'b1;
	assign prdata = (ffca_reg_t'(paddr[2]) == REG_ENTRIES_IN_USE) ?
	                APB_DATA_W'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready &&
		             ffca_reg_t'(paddr[2]) == REG_ENTRIES_IN_USE) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		chain[0].valid  = s_tvalid;
		chain[0].kind   = ffca_req_t'(s_tuser);
		chain[0].done   = 1'b0;
		chain[0].slot   = s_tdata[SLOT_W-1:0];
		chain[0].amount = s_tdata[SLOT_W+AMOUNT_W-1:SLOT_W];
		chain[0].grant  = '0;
	end

	for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
		ffca_cell #(
			.CELL_INDEX   (g),
			.CAPACITY_BITS(CAPACITY_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.limit   (limit_q),
			.item_in (chain[g]),
			.item_out(chain[g+1])
		);
	end

	assign last     = chain[SLOT_COUNT];
	assign m_tvalid = last.valid && (last.kind == REQ_ALLOC);
	assign m_tdata  = OUT_DATA_W'(last.grant);
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = advance;

endmodule

// ----- rtl/ffca_checker.sv -----
// ----------------------------------------------------------------------------
// First-fit capacity allocator: port checker
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`include "first_fit_capacity_allocator_core_macros.svh"

module ffca_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [ffca_pkg::OUT_DATA_W-1:0] m_tdata
);
	import ffca_pkg::*;

	`FFCA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed while stalled")
	`FFCA_ASSERT(a_ready_follows_out, s_tready == (!m_tvalid || m_tready), "input ready does not follow the output stall")
	`FFCA_ASSERT(a_grant_fill, m_tvalid |-> (m_tdata[OUT_DATA_W-1:GRANT_W] == '0), "fill bits of a result item are not zero")

endmodule

bind first_fit_capacity_allocator_core ffca_checker u_ffca_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
